>>> rtl/core/task_time_welford_stats_defines.svh
// Assertion macros for the task time statistics block.
`ifndef TASK_TIME_WELFORD_STATS_DEFINES_SVH
`define TASK_TIME_WELFORD_STATS_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TTWS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TTWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TTWS_ASSERT(lbl, clk, rst_n, prop, msg)

`define TTWS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/ttws_pkg.sv
package ttws_pkg;

	localparam int TICK_W    = 32;
	localparam int ACC_W     = 64;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [TICK_W-1:0] ALL_ONES32 = 32'hffff_ffff;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_TASK  = 2'd1,
		OP_IDLE  = 2'd2,
		OP_CLEAR = 2'd3
	} op_e_t;

	typedef struct packed {
		op_e_t             op;
		logic [TICK_W-1:0] ticks;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [TICK_W-1:0] dividend;
		logic [TICK_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [TICK_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_EMIT
	} back_state_t;

endpackage

>>> rtl/core/ttws_front.sv
module ttws_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,  // [31:0] elapsed_ticks
	input  logic [1:0]            s_axis_tuser,  // [1:0] func
	output logic                  push_vld,
	output ttws_pkg::item_t       push_item,
	input  logic                  push_rdy
);

	logic            vld_q;
	ttws_pkg::item_t item_q;
	ttws_pkg::op_e_t op_c;
	logic            accept;

	assign op_c          = ttws_pkg::op_e_t'(s_axis_tuser);
	assign s_axis_tready = !vld_q || push_rdy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (push_rdy) begin
			vld_q <= 1'b0;
		end
	end

	// drop the tick count for codes that ignore it
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op <= op_c;
			unique case (op_c)
				ttws_pkg::OP_ADD,
				ttws_pkg::OP_TASK: item_q.ticks <= s_axis_tdata;
				default:           item_q.ticks <= '0;
			endcase
		end
	end

	assign push_vld  = vld_q;
	assign push_item = item_q;

endmodule

>>> rtl/core/ttws_queue.sv
module ttws_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_vld,
	input  ttws_pkg::item_t push_item,
	output logic            push_rdy,
	output logic            pop_vld,
	output ttws_pkg::item_t pop_item,
	input  logic            pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ttws_pkg::item_t  slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_rdy = count_q != CNT_W'(DEPTH);
	assign pop_vld  = count_q != '0;
	assign pop_item = slots_q[rd_ptr_q];
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop && pop_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/core/ttws_div.sv
module ttws_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ttws_pkg::div_req_t req,
	output ttws_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [ttws_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [ttws_pkg::TICK_W-1:0]         rem_q;
	logic [ttws_pkg::TICK_W-1:0]         quo_q;
	logic [ttws_pkg::TICK_W-1:0]         dsr_q;
	logic [ttws_pkg::TICK_W:0]           rem_sh;
	logic [ttws_pkg::TICK_W:0]           dsr_ext;
	logic                                fits;

	// one restoring step per cycle, quotient bits shift in from the right
	assign rem_sh  = {rem_q, quo_q[ttws_pkg::TICK_W-1]};
	assign dsr_ext = {1'b0, dsr_q};
	assign fits    = rem_sh >= dsr_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ttws_pkg::DIV_CNT_W'(ttws_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? ttws_pkg::TICK_W'(rem_sh - dsr_ext)
			              : rem_sh[ttws_pkg::TICK_W-1:0];
			quo_q <= {quo_q[ttws_pkg::TICK_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/core/ttws_back.sv
module ttws_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_vld,
	input  ttws_pkg::item_t     item,
	output logic                pop,
	output ttws_pkg::div_req_t  div_req,
	input  ttws_pkg::div_rsp_t  div_rsp,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [223:0]        m_axis_tdata
);

	ttws_pkg::back_state_t state_q;
	ttws_pkg::back_state_t state_nxt;

	logic [31:0]        total_q;
	logic [31:0]        seg_q;
	logic [31:0]        mean_q;
	logic [63:0]        acc_q;
	logic [31:0]        min_q;
	logic [31:0]        max_q;
	logic [31:0]        t_q;
	logic signed [31:0] d1_q;
	logic signed [63:0] prod_q;

	logic               out_vld_q;
	logic [223:0]       out_q;
	logic               out_free;
	logic               out_load;
	logic               div_start;

	logic [31:0]        t_c;
	logic [31:0]        n_c;
	logic [31:0]        q_signed;
	logic signed [31:0] d2_c;
	logic signed [63:0] prod_c;

	assign t_c      = seg_q + item.ticks;
	assign n_c      = total_q + 32'd1;
	assign q_signed = d1_q[31] ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;
	assign d2_c     = t_q - mean_q;
	assign prod_c   = d1_q * d2_c;
	assign out_free = !out_vld_q || m_axis_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ttws_pkg::ST_IDLE: begin
				if (item_vld) begin
					if (item.op == ttws_pkg::OP_TASK) begin
						// count wrapped to zero: mean stays, skip the divide
						state_nxt = (n_c == 32'd0) ? ttws_pkg::ST_MUL : ttws_pkg::ST_DIV_GO;
					end else begin
						state_nxt = ttws_pkg::ST_EMIT;
					end
				end
			end
			ttws_pkg::ST_DIV_GO: state_nxt = ttws_pkg::ST_DIV;
			ttws_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_nxt = ttws_pkg::ST_MUL;
				end
			end
			ttws_pkg::ST_MUL: state_nxt = ttws_pkg::ST_ACC;
			ttws_pkg::ST_ACC: state_nxt = ttws_pkg::ST_EMIT;
			ttws_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nxt = ttws_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ttws_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == ttws_pkg::ST_IDLE) && item_vld;
		div_start = state_q == ttws_pkg::ST_DIV_GO;
		out_load  = (state_q == ttws_pkg::ST_EMIT) && out_free;
	end

	assign div_req.start    = div_start;
	assign div_req.dividend = d1_q[31] ? (32'd0 - d1_q) : d1_q;
	assign div_req.divisor  = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ttws_pkg::ST_IDLE;
			out_vld_q <= 1'b0;
			total_q   <= '0;
			seg_q     <= '0;
			mean_q    <= '0;
			acc_q     <= '0;
			min_q     <= ttws_pkg::ALL_ONES32;
			max_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (pop) begin
				unique case (item.op)
					ttws_pkg::OP_ADD: seg_q <= t_c;
					ttws_pkg::OP_TASK: begin
						total_q <= n_c;
						seg_q   <= '0;
					end
					ttws_pkg::OP_IDLE: begin
						total_q <= n_c;
						mean_q  <= mean_q + seg_q;
					end
					ttws_pkg::OP_CLEAR: begin
						total_q <= '0;
						seg_q   <= '0;
						mean_q  <= '0;
						acc_q   <= '0;
						min_q   <= ttws_pkg::ALL_ONES32;
						max_q   <= '0;
					end
					default: seg_q <= seg_q;
				endcase
			end
			if (state_q == ttws_pkg::ST_DIV && div_rsp.done) begin
				mean_q <= mean_q + q_signed;
			end
			if (state_q == ttws_pkg::ST_ACC) begin
				acc_q <= acc_q + prod_q;
				if (t_q < min_q) begin
					min_q <= t_q;
				end
				if (t_q > max_q) begin
					max_q <= t_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.op == ttws_pkg::OP_TASK) begin
			t_q  <= t_c;
			d1_q <= t_c - mean_q;
		end
		if (state_q == ttws_pkg::ST_MUL) begin
			prod_q <= prod_c;
		end
		if (out_load) begin
			out_q <= {max_q, min_q, acc_q, mean_q, seg_q, total_q};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

>>> rtl/core/task_time_welford_stats.sv
// Channel    | Dir | Handshake              | Payload
// s_axis     | in  | s_axis_tvalid/tready   | tuser: func; tdata: elapsed_ticks
// m_axis     | out | m_axis_tvalid/tready   | tdata: run_count .. max_ticks
//
// Add, idle finish and clear: the back end goes from idle straight to its emit state.
// Finish task: the back end starts the 32-step serial divider, waits for it to finish,
// then runs the multiply and accumulate steps; the divide is skipped when the run count wraps.
// While the back end works, the front stage and queue take items until the queue is full.
// Reset clears all statistics (min to all ones) and empties the queue.
// The result register holds while m_axis_tready is low.
`include "task_time_welford_stats_defines.svh"

module task_time_welford_stats #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // [31:0] elapsed_ticks
	input  logic [1:0]   s_axis_tuser,   // [1:0] func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [223:0] m_axis_tdata    // run_count, running_ticks, mean_ticks,
	                                     // sum_sq_dev, min_ticks, max_ticks
);

	logic               push_vld;
	logic               push_rdy;
	ttws_pkg::item_t    push_item;
	logic               q_vld;
	ttws_pkg::item_t    q_item;
	logic               q_pop;
	ttws_pkg::div_req_t div_req;
	ttws_pkg::div_rsp_t div_rsp;
	logic [31:0]        out_min;
	logic [31:0]        out_max;
	logic               min_set;

	ttws_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_vld      (push_vld),
		.push_item     (push_item),
		.push_rdy      (push_rdy)
	);

	ttws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (push_vld),
		.push_item (push_item),
		.push_rdy  (push_rdy),
		.pop_vld   (q_vld),
		.pop_item  (q_item),
		.pop       (q_pop)
	);

	ttws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ttws_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_vld      (q_vld),
		.item          (q_item),
		.pop           (q_pop),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	assign out_min = m_axis_tdata[191:160];
	assign out_max = m_axis_tdata[223:192];
	assign min_set = out_min != ttws_pkg::ALL_ONES32;

	`TTWS_ASSERT(a_pop_has_item, clk, arst_n, q_pop |-> q_vld, "pop from empty queue")
	`TTWS_ASSERT(a_div_not_busy, clk, arst_n, div_req.start |-> !div_rsp.busy, "divider busy")
	`TTWS_ASSERT(a_min_le_max, clk, arst_n, m_axis_tvalid && min_set |-> out_min <= out_max, "min>max")
	`TTWS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule
